// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/sprd_pkg.sv
// ---------------------------------------------------------------------------
// sprd_pkg
// shared types and codes of the 6pack receive deframer
// ---------------------------------------------------------------------------
package sprd_pkg;

	localparam int LEN_W   = 10;
	localparam int MAX_RES = 4;
	localparam int NRES_W  = 3;

	// result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_EOF  = 2'd1;
	localparam logic [1:0] KIND_LED  = 2'd2;

	// frame status codes
	localparam logic [1:0] STAT_GOOD = 2'd0;
	localparam logic [1:0] STAT_BAD  = 2'd1;
	localparam logic [1:0] STAT_LONG = 2'd2;

	// led bytes
	localparam logic [7:0] LED_OFF = 8'h60;
	localparam logic [7:0] LED_CON = 8'h68;

	// link bytes
	localparam logic [7:0] BYTE_INIT = 8'hE8;
	localparam logic [4:0] CMD_EOF   = 5'b01000;
	localparam logic [7:0] SUM_GOOD  = 8'hFF;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic [1:0]       fstat;
		logic [LEN_W-1:0] len;
		logic [7:0]       led;
		logic [2:0]       link;
		logic             last;
	} result_t;

	typedef struct packed {
		result_t [MAX_RES-1:0] res;
		logic [NRES_W-1:0]     n;
	} burst_t;

endpackage

// File: hw/rtl/sprd_decode.sv
// ---------------------------------------------------------------------------
// sprd_decode
// link state, sextet packing and frame bookkeeping; builds the result burst
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sprd_decode #(
	parameter int MAX_FRAME = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        rx_byte,
	output sprd_pkg::burst_t  burst
);

	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam int LW    = sprd_pkg::LEN_W;

	typedef struct packed {
		logic [7:0]       sum;
		logic [CNT_W-1:0] cnt;
		logic             ovf;
	} acc_t;

	function automatic acc_t step_acc(input acc_t a, input logic [7:0] b);
		acc_t r;
		r = a;
		r.sum = a.sum + b;
		if (a.cnt < CNT_W'(MAX_FRAME)) begin
			r.cnt = a.cnt + 1'b1;
		end else begin
			r.ovf = 1'b1;
		end
		return r;
	endfunction

	function automatic sprd_pkg::result_t mk(input logic [1:0] kind, input logic [7:0] data,
			input logic [1:0] fstat, input logic [LW-1:0] len, input logic [7:0] led,
			input logic [2:0] link, input logic last);
		sprd_pkg::result_t r;
		r.kind  = kind;
		r.data  = data;
		r.fstat = fstat;
		r.len   = len;
		r.led   = led;
		r.link  = link;
		r.last  = last;
		return r;
	endfunction

	logic [2:0]       ls_q, ls_n;
	logic [1:0]       gp_q, gp_n;
	logic [5:0]       st_q [3];
	logic [5:0]       st_n [3];
	logic [7:0]       sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	acc_t             acc_n;

	acc_t             a0, a1, a2, a3, fin;
	logic [7:0]       fb, sb, tb;
	logic [CNT_W-1:0] len_c;
	logic [1:0]       fstat_c;
	logic             eof_cmd, empty_frame, rx_on;
	logic [2:0]       pcmd;

	always_comb begin
		fb = {st_q[1][5:4], st_q[0]};
		sb = {st_q[2][5:2], st_q[1][3:0]};
		tb = {rx_byte[5:0], st_q[2][1:0]};
		a0 = '{sum: sum_q, cnt: cnt_q, ovf: ovf_q};
		a1 = step_acc(a0, fb);
		a2 = step_acc(a1, sb);
		a3 = step_acc(a2, tb);
		case (gp_q)
			2'd2:    fin = a1;
			2'd3:    fin = a2;
			default: fin = a0;
		endcase
		len_c   = (fin.cnt == '0) ? '0 : fin.cnt - 1'b1;
		fstat_c = fin.ovf ? sprd_pkg::STAT_LONG :
			((fin.sum == sprd_pkg::SUM_GOOD) ? sprd_pkg::STAT_GOOD : sprd_pkg::STAT_BAD);
		eof_cmd     = (rx_byte[7:3] == sprd_pkg::CMD_EOF);
		empty_frame = (gp_q == 2'd0) && (cnt_q == '0);
		rx_on       = (ls_q[1:0] == 2'b11);
		// protocol violation: rx and dcd raised together while dcd was clear
		pcmd = rx_byte[5:3];
		if (!ls_q[0] && (pcmd[1:0] == 2'b11)) begin
			pcmd[1:0] = 2'b00;
		end
	end

	always_comb begin
		ls_n  = ls_q;
		gp_n  = gp_q;
		st_n  = st_q;
		acc_n = a0;
		burst = '0;
		if (rx_byte == sprd_pkg::BYTE_INIT) begin
			// init byte, nothing happens
		end else if (rx_byte[7]) begin
			if (rx_byte[5:3] != 3'b000) begin
				ls_n = pcmd;
			end
		end else if (rx_byte[6]) begin
			if (eof_cmd) begin
				if (empty_frame) begin
					if (rx_on) begin
						burst.n = 3'd1;
						burst.res[0] = mk(sprd_pkg::KIND_LED, 8'h00, 2'd0, '0,
							sprd_pkg::LED_CON, ls_q, 1'b1);
					end
				end else begin
					burst.res[0] = mk(sprd_pkg::KIND_LED, 8'h00, 2'd0, '0,
						sprd_pkg::LED_OFF, ls_q, 1'b0);
					burst.res[1] = mk(sprd_pkg::KIND_DATA, fb, 2'd0, '0, 8'h00, ls_q, 1'b0);
					burst.res[2] = mk(sprd_pkg::KIND_DATA, sb, 2'd0, '0, 8'h00, ls_q, 1'b0);
					case (gp_q)
						2'd2: begin
							burst.n = 3'd3;
							burst.res[2] = mk(sprd_pkg::KIND_EOF, 8'h00, fstat_c, LW'(len_c),
								8'h00, ls_q, 1'b1);
						end
						2'd3: begin
							burst.n = 3'd4;
							burst.res[3] = mk(sprd_pkg::KIND_EOF, 8'h00, fstat_c, LW'(len_c),
								8'h00, ls_q, 1'b1);
						end
						default: begin
							// a lone sextet is dropped
							burst.n = 3'd2;
							burst.res[1] = mk(sprd_pkg::KIND_EOF, 8'h00, fstat_c, LW'(len_c),
								8'h00, ls_q, 1'b1);
						end
					endcase
					gp_n  = 2'd0;
					st_n  = '{default: '0};
					acc_n = '0;
				end
			end
		end else if (rx_on) begin
			if (gp_q != 2'd3) begin
				st_n[gp_q] = rx_byte[5:0];
				gp_n = gp_q + 2'd1;
			end else begin
				burst.n = 3'd3;
				burst.res[0] = mk(sprd_pkg::KIND_DATA, fb, 2'd0, '0, 8'h00, ls_q, 1'b0);
				burst.res[1] = mk(sprd_pkg::KIND_DATA, sb, 2'd0, '0, 8'h00, ls_q, 1'b0);
				burst.res[2] = mk(sprd_pkg::KIND_DATA, tb, 2'd0, '0, 8'h00, ls_q, 1'b1);
				gp_n  = 2'd0;
				acc_n = a3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q  <= '0;
			gp_q  <= '0;
			st_q  <= '{default: '0};
			sum_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (adv) begin
			ls_q  <= ls_n;
			gp_q  <= gp_n;
			st_q  <= st_n;
			sum_q <= acc_n.sum;
			cnt_q <= acc_n.cnt;
			ovf_q <= acc_n.ovf;
		end
	end

	`ASSERT_NXT(a_eof_clears, adv && (rx_byte[7:3] == sprd_pkg::CMD_EOF) && !empty_frame, (gp_q == 2'd0) && (cnt_q == '0) && !ovf_q, "frame state not cleared at frame end")
	`ASSERT_IMP(a_cnt_sat, 1'b1, cnt_q <= CNT_W'(MAX_FRAME), "byte count past limit")

endmodule

// File: hw/rtl/sprd_burst.sv
// ---------------------------------------------------------------------------
// sprd_burst
// result register: holds the results of one item and, while out_stall is low, sends one per cycle
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sprd_burst (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sprd_pkg::burst_t  burst,
	output logic              free,
	output logic              out_valid,
	input  logic              out_stall,
	output sprd_pkg::result_t head
);

	localparam int N = sprd_pkg::MAX_RES;

	sprd_pkg::result_t             res_q [N];
	logic [sprd_pkg::NRES_W-1:0]   cnt_q;
	logic                          fire;

	assign out_valid = (cnt_q != '0);
	assign fire      = out_valid && !out_stall;
	// free when empty, or once the last held result leaves this cycle
	assign free      = (cnt_q == '0) || ((cnt_q == 3'd1) && !out_stall);
	assign head      = res_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= burst.n;
		end else if (fire) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < N; i++) begin
				res_q[i] <= burst.res[i];
			end
		end else if (fire) begin
			for (int i = 0; i < N - 1; i++) begin
				res_q[i] <= res_q[i + 1];
			end
		end
	end

	`ASSERT_IMP(a_load_free, load, free, "burst loaded while results remain")
	`ASSERT_IMP(a_last_tail, out_valid, res_q[0].last == (cnt_q == 3'd1), "last flag out of place")
	`ASSERT_NXT(a_drain, fire && (cnt_q > 3'd1), out_valid, "burst lost results")

endmodule

// File: hw/rtl/sixpack_receive_deframer.sv
// ---------------------------------------------------------------------------
// sixpack_receive_deframer
// 6pack tnc receive side: link status, sextet unpacking, frame end and checksum
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  input   | in_valid / in_stall   | rx_byte
//  output  | out_valid / out_stall | kind data_byte frame_status frame_length
//          |                       | led_code link_status last
//
//  an item is taken into the input register, decoded there, and its results are
//  loaded into the result register once that is free; the first result shows on
//  the output as soon as the load is done
//  an item has k results (k is 0 to 4), sent one at a time through the single
//  output port that drains the result register; an item in the input register
//  moves on, and the next one is taken, in the cycle the last result of the
//  previous one leaves
//  arst_n clears link status and frame state at once; no clearing pass
// ---------------------------------------------------------------------------
module sixpack_receive_deframer #(
	parameter int MAX_FRAME = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [1:0] frame_status,
	output logic [9:0] frame_length,
	output logic [7:0] led_code,
	output logic [2:0] link_status,
	output logic       last
);

	// input register
	logic              valid_s1;
	logic [7:0]        rx_byte_s1;
	// handoff to the result register
	logic              free;
	logic              adv;
	sprd_pkg::burst_t  burst;
	sprd_pkg::result_t head;

	// the input register moves on when the result register can take its burst;
	// items with no results still wait for a free result register but load nothing
	assign adv      = valid_s1 && free;
	assign in_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// decode: link status, sextet store, running sum and byte count
	sprd_decode #(
		.MAX_FRAME(MAX_FRAME)
	) u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.rx_byte (rx_byte_s1),
		.burst   (burst)
	);

	// result register, one result per cycle while out_stall is low
	sprd_burst u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && (burst.n != '0)),
		.burst     (burst),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	// result fields
	assign kind         = head.kind;
	assign data_byte    = head.data;
	assign frame_status = head.fstat;
	assign frame_length = head.len;
	assign led_code     = head.led;
	assign link_status  = head.link;
	assign last         = head.last;

endmodule

// File: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for sixpack_receive_deframer: a queue of link bytes
// (directed cases, well-formed frames with noise, junk) feeds a valid/stall
// driver, an in-bench decoder predicts every result and a monitor compares
// each one field by field
// ---------------------------------------------------------------------------
module tb;

	localparam int FRAME_LIMIT  = 512;
	localparam int RANDOM_BYTES = 380;
	localparam int MAX_WAIT     = 16;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 20;

	// one queued link byte; drain holds it back until every result is in
	typedef struct {
		logic [7:0] value;
		bit         drain;
	} link_byte_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [1:0] frame_status;
	logic [9:0] frame_length;
	logic [7:0] led_code;
	logic [2:0] link_status;
	logic       last;

	sixpack_receive_deframer #(
		.MAX_FRAME(FRAME_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.data_byte(data_byte),
		.frame_status(frame_status),
		.frame_length(frame_length),
		.led_code(led_code),
		.link_status(link_status),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// decoder state mirrored by the bench
	// -----------------------------------------------------------------------
	logic [2:0] link_bits      = 3'b000;  // bit2 tx, bit1 rx, bit0 dcd
	logic [1:0] group_fill     = 2'd0;    // sextets held in the open group
	logic [5:0] sextets [3]    = '{default: 6'd0};
	logic [7:0] frame_sum      = 8'h00;
	logic [9:0] frame_bytes    = 10'd0;   // saturates at the frame limit
	logic       frame_overflow = 1'b0;

	sprd_pkg::result_t decoded_results [$];  // results still to come from the dut
	sprd_pkg::result_t byte_results [$];     // results of the byte being decoded
	link_byte_t        link_bytes [$];       // bytes not yet offered to the dut

	int  results_predicted = 0;
	int  results_seen      = 0;           // written with nba only, see driver
	int  results_checked   = 0;
	int  bytes_sent        = 0;
	int  frames_ended      = 0;
	int  long_frames       = 0;
	int  errors            = 0;
	bit  drain_next        = 1'b0;

	function automatic sprd_pkg::result_t make_result(input logic [1:0] k,
			input logic [7:0] d, input logic [1:0] st, input logic [9:0] len,
			input logic [7:0] led);
		sprd_pkg::result_t r;
		r.kind  = k;
		r.data  = d;
		r.fstat = st;
		r.len   = len;
		r.led   = led;
		r.link  = link_bits;
		r.last  = 1'b0;
		return r;
	endfunction

	// a decoded frame byte: streamed out, summed, counted up to the limit
	task automatic add_frame_byte(input logic [7:0] v);
		frame_sum = frame_sum + v;
		if (frame_bytes < FRAME_LIMIT)
			frame_bytes++;
		else
			frame_overflow = 1'b1;
		byte_results.push_back(make_result(sprd_pkg::KIND_DATA, v, sprd_pkg::STAT_GOOD,
			'0, '0));
	endtask

	// works out what one accepted link byte makes the dut send
	task automatic decode_link_byte(input logic [7:0] b);
		logic [7:0] cmd;
		logic [1:0] st;
		byte_results.delete();
		if (b == sprd_pkg::BYTE_INIT) begin
			// init byte from the tnc, no effect at all
		end else if (b[7]) begin
			// priority command; bits 5:3 all clear leave the status alone
			if (b[5:3] != 3'b000) begin
				cmd = b;
				// rx and dcd raised together while dcd was low is a protocol error
				if (!link_bits[0] && cmd[4:3] == 2'b11)
					cmd[4:3] = 2'b00;
				link_bits = cmd[5:3];
			end
		end else if (b[6]) begin
			// standard command; only the end-of-frame group acts
			if (b[7:3] == sprd_pkg::CMD_EOF) begin
				if (group_fill == 2'd0 && frame_bytes == 10'd0) begin
					// empty frame end: connect led, only while receiving
					if (link_bits[1:0] == 2'b11)
						byte_results.push_back(make_result(sprd_pkg::KIND_LED, '0,
							sprd_pkg::STAT_GOOD, '0, sprd_pkg::LED_CON));
				end else begin
					byte_results.push_back(make_result(sprd_pkg::KIND_LED, '0,
						sprd_pkg::STAT_GOOD, '0, sprd_pkg::LED_OFF));
					// pad the open group; a lone sextet is dropped
					if (group_fill == 2'd2) begin
						add_frame_byte({sextets[1][5:4], sextets[0]});
					end else if (group_fill == 2'd3) begin
						add_frame_byte({sextets[1][5:4], sextets[0]});
						add_frame_byte({sextets[2][5:2], sextets[1][3:0]});
					end
					if (frame_overflow)
						st = sprd_pkg::STAT_LONG;
					else if (frame_sum == sprd_pkg::SUM_GOOD)
						st = sprd_pkg::STAT_GOOD;
					else
						st = sprd_pkg::STAT_BAD;
					byte_results.push_back(make_result(sprd_pkg::KIND_EOF, '0, st,
						(frame_bytes != 10'd0) ? frame_bytes - 10'd1 : 10'd0, '0));
					frames_ended++;
					if (st == sprd_pkg::STAT_LONG)
						long_frames++;
					group_fill     = 2'd0;
					sextets        = '{default: 6'd0};
					frame_sum      = 8'h00;
					frame_bytes    = 10'd0;
					frame_overflow = 1'b0;
				end
			end
		end else if (link_bits[1:0] == 2'b11) begin
			// data sextet, taken only while rx and dcd are both up
			if (group_fill != 2'd3) begin
				sextets[group_fill] = b[5:0];
				group_fill++;
			end else begin
				add_frame_byte({sextets[1][5:4], sextets[0]});
				add_frame_byte({sextets[2][5:2], sextets[1][3:0]});
				add_frame_byte({b[5:0], sextets[2][1:0]});
				group_fill = 2'd0;
			end
		end
		if (byte_results.size() != 0) begin
			byte_results[byte_results.size() - 1].last = 1'b1;
			foreach (byte_results[i])
				decoded_results.push_back(byte_results[i]);
			results_predicted += byte_results.size();
		end
	endtask

	// -----------------------------------------------------------------------
	// stimulus building
	// -----------------------------------------------------------------------
	task automatic queue_byte(input logic [7:0] v);
		link_byte_t e;
		e.value    = v;
		e.drain    = drain_next;
		drain_next = 1'b0;
		link_bytes.push_back(e);
	endtask

	// bytes the decoder must skip without disturbing the frame
	task automatic queue_noise();
		case ($urandom_range(0, 2))
			0: queue_byte(sprd_pkg::BYTE_INIT);
			1: queue_byte(8'h48 + 8'($urandom_range(0, 55)));
			default: queue_byte({1'b1, 1'($urandom_range(0, 1)), 3'b000,
				3'($urandom_range(0, 7))});
		endcase
	endtask

	// link up, n frame bytes packed four sextets per three bytes, frame end
	task automatic queue_frame(input int n, input bit good_sum, input int noise_pct);
		logic [7:0] fbytes [$];
		logic [7:0] sum;
		logic [7:0] b0, b1, b2;
		logic [5:0] sx [4];
		int         nsx;
		bit         tx;
		tx  = 1'($urandom_range(0, 1));
		sum = 8'h00;
		// dcd first so that rx plus dcd is legal; skipped now and then
		if ($urandom_range(0, 9) != 0)
			queue_byte({1'b1, 1'($urandom_range(0, 1)), tx, 2'b01, 3'($urandom_range(0, 7))});
		queue_byte({1'b1, 1'($urandom_range(0, 1)), tx, 2'b11, 3'($urandom_range(0, 7))});
		for (int i = 0; i < n; i++) begin
			fbytes.push_back(8'($urandom_range(0, 255)));
			sum = sum + fbytes[i];
		end
		// fix the last byte so the whole frame sums to the good value
		if (good_sum && n > 0)
			fbytes[n - 1] = fbytes[n - 1] + (sprd_pkg::SUM_GOOD - sum);
		for (int i = 0; i < n; i += 3) begin
			b0    = fbytes[i];
			b1    = (i + 1 < n) ? fbytes[i + 1] : 8'h00;
			b2    = (i + 2 < n) ? fbytes[i + 2] : 8'h00;
			sx[0] = b0[5:0];
			sx[1] = {b0[7:6], b1[3:0]};
			sx[2] = {b1[7:4], b2[1:0]};
			sx[3] = b2[7:2];
			nsx   = (n - i >= 3) ? 4 : n - i + 1;
			for (int j = 0; j < nsx; j++) begin
				if ($urandom_range(1, 100) <= noise_pct)
					queue_noise();
				queue_byte({2'b00, sx[j]});
			end
		end
		// a stray sextet that opens a group and is dropped at frame end
		if (n % 3 == 0 && $urandom_range(0, 7) == 0)
			queue_byte({2'b00, 6'($urandom_range(0, 63))});
		queue_byte({sprd_pkg::CMD_EOF, 3'($urandom_range(0, 7))});
	endtask

	// -----------------------------------------------------------------------
	// driver: one item offered at a time, gap drawn per item, results predicted
	// at acceptance; the drain check reads results_seen, which changes only by nba
	// -----------------------------------------------------------------------
	link_byte_t next_item;
	int         gap_left = 0;
	bit         calm_in  = 1'b0;
	bit         took;

	always @(posedge clk) begin
		if (arst_n) begin
			took = in_valid && !in_stall;
			if (took) begin
				decode_link_byte(rx_byte);
				bytes_sent++;
			end
			if (!in_valid || took) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (link_bytes.size() != 0 &&
						!(link_bytes[0].drain && results_seen != results_predicted)) begin
					next_item = link_bytes.pop_front();
					in_valid <= 1'b1;
					rx_byte  <= next_item.value;
					// stretches without gaps come and go
					if ($urandom_range(0, 39) == 0)
						calm_in = !calm_in;
					gap_left = calm_in ? 0 : $urandom_range(0, MAX_WAIT);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// monitor: every accepted result against the oldest prediction
	// -----------------------------------------------------------------------
	sprd_pkg::result_t want;
	int                stall_left = 0;
	bit                calm_out   = 1'b0;

	task automatic check_field(input string what, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (decoded_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual kind %0h data %0h",
						$time, kind, data_byte);
					errors++;
				end else begin
					want = decoded_results.pop_front();
					check_field("kind", 16'(want.kind), 16'(kind));
					check_field("data_byte", 16'(want.data), 16'(data_byte));
					check_field("frame_status", 16'(want.fstat), 16'(frame_status));
					check_field("frame_length", 16'(want.len), 16'(frame_length));
					check_field("led_code", 16'(want.led), 16'(led_code));
					check_field("link_status", 16'(want.link), 16'(link_status));
					check_field("last", 16'(want.last), 16'(last));
					results_checked++;
					results_seen <= results_seen + 1;
				end
				if ($urandom_range(0, 39) == 0)
					calm_out = !calm_out;
				stall_left = calm_out ? 0 : $urandom_range(0, MAX_WAIT);
			end else if (stall_left != 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	// -----------------------------------------------------------------------
	// watchdog: cycles in which no item moves on either side
	// -----------------------------------------------------------------------
	int idle_cycles = 0;

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: timeout, nothing moved for %0d cycles", $time, IDLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// -----------------------------------------------------------------------
	// stimulus and end of run
	// -----------------------------------------------------------------------
	int  random_start;
	bit  mid_drain_done = 1'b0;

	initial begin
		// directed: link idle, so data and frame end do nothing
		queue_byte(8'h00);
		queue_byte(sprd_pkg::BYTE_INIT);
		queue_byte(8'h80);                       // priority, no status bits
		queue_byte({sprd_pkg::CMD_EOF, 3'd0});   // empty frame end while idle
		queue_byte(8'h98);                       // rx and dcd with dcd low: rejected
		queue_byte(8'h7F);                       // other standard commands
		queue_byte(8'h48);
		queue_byte(8'hC8);                       // dcd, bit 6 set
		queue_byte(8'hF8);                       // tx rx dcd, now legal
		queue_byte({sprd_pkg::CMD_EOF, 3'd7});   // empty frame end: connect led
		repeat (4) queue_byte(8'h3F);            // full group of all ones
		queue_byte(8'h00);                       // lone sextet, dropped at end
		queue_byte({sprd_pkg::CMD_EOF, 3'd0});
		queue_byte(8'h00);                       // three sextets: two padded bytes
		queue_byte(8'h3F);
		queue_byte(8'h15);
		queue_byte({sprd_pkg::CMD_EOF, 3'd5});
		queue_byte(8'h2A);                       // two sextets: one padded byte
		queue_byte(8'h01);
		queue_byte({sprd_pkg::CMD_EOF, 3'd3});
		queue_byte(8'h87);                       // no status bits, low bits set
		queue_byte(8'hFF);
		queue_byte(8'hA0);                       // tx only, receive off

		// random: mostly frames with content and noise, the rest junk
		drain_next   = 1'b1;
		random_start = link_bytes.size();
		while (link_bytes.size() - random_start < RANDOM_BYTES) begin
			if (!mid_drain_done && link_bytes.size() - random_start > RANDOM_BYTES / 2) begin
				drain_next     = 1'b1;
				mid_drain_done = 1'b1;
			end
			if ($urandom_range(0, 99) < 75)
				queue_frame(($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
					: $urandom_range(0, 24), $urandom_range(0, 4) != 0,
					$urandom_range(0, 1) * 8);
			else
				repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(0, 255)));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (link_bytes.size() != 0 || in_valid || results_seen != results_predicted)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d link bytes sent, %0d results checked", bytes_sent, results_checked);
		$display("%0d frame ends, %0d over the length limit", frames_ended, long_frames);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
